[hdl/ptt_pkg.sv]
// shared types, codes and tick arithmetic for the periodic timer table
package ptt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_DONE = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic signed [15:0] COUNT_FLOOR = 16'sh8000;

    typedef struct packed {
        logic [15:0] obj;
        logic [14:0] per;
        logic [15:0] cnt;
        logic        hnd;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD
    } cell_op_t;

    typedef struct packed {
        logic rotate;
        logic compact;
        logic load;
    } chain_cmd_t;

    typedef struct packed {
        entry_t e;
        logic   fire;
    } tick_res_t;

    function automatic tick_res_t tick_entry(entry_t e);
        tick_res_t       r;
        logic signed [15:0] c;
        c = $signed(e.cnt);
        if (c != COUNT_FLOOR)
        begin
            c = c - 16'sd1;
        end
        r.e = e;
        r.fire = e.hnd && (c < 16'sd1);
        if (r.fire)
        begin
            r.e.cnt = {1'b0, e.per};
        end
        else
        begin
            r.e.cnt = c;
        end
        return r;
    endfunction

endpackage

[hdl/ptt_cell.sv]
// one table entry register with hold, shift and load
module ptt_cell (
    input  logic              clk,
    input  ptt_pkg::cell_op_t op,
    input  ptt_pkg::entry_t   neighbor,
    input  ptt_pkg::entry_t   load_data,
    output ptt_pkg::entry_t   q
);
    import ptt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        unique case (op)
            CELL_SHIFT: entry_next = neighbor;
            CELL_LOAD:  entry_next = load_data;
            default:    entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

[hdl/ptt_chain.sv]
// row of entry cells forming a rotating ring with compaction and load
module ptt_chain #(
    parameter int DEPTH = ptt_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  ptt_pkg::chain_cmd_t  cmd,
    input  logic [IDX_W-1:0]     pos,
    input  ptt_pkg::entry_t      tail_data,
    input  ptt_pkg::entry_t      load_data,
    output ptt_pkg::entry_t      head
);
    import ptt_pkg::*;

    entry_t   q    [DEPTH];
    entry_t   nb   [DEPTH];
    cell_op_t op   [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH - 1)
        begin : g_tail
            assign nb[i] = tail_data;
        end
        else
        begin : g_mid
            assign nb[i] = q[i+1];
        end

        always_comb
        begin
            if (cmd.rotate)
            begin
                op[i] = CELL_SHIFT;
            end
            else if (cmd.compact && (IDX_W'(i) >= pos))
            begin
                op[i] = (i == DEPTH - 1) ? CELL_HOLD : CELL_SHIFT;
            end
            else if (cmd.load && (IDX_W'(i) == pos))
            begin
                op[i] = CELL_LOAD;
            end
            else
            begin
                op[i] = CELL_HOLD;
            end
        end

        ptt_cell u_cell (
            .clk       (clk),
            .op        (op[i]),
            .neighbor  (nb[i]),
            .load_data (load_data),
            .q         (q[i])
        );
    end

    assign head = q[0];

endmodule

[hdl/periodic_timer_table_top.sv]
// periodic timer table top level: command sequencer around the entry ring
// tick: one ring walk over every entry, fire beats during the walk, closing beat after
// set and query: a search walk over every entry, then an apply step that reports the result
// unknown kind: single beat in the cycle after start, busy stays low
// one command at a time; results are strobed for one cycle and cannot be stalled
// reset empties the table at once; entry contents are left as they are
module periodic_timer_table_top #(
    parameter int TABLE_DEPTH = ptt_pkg::TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         kind,
    input  logic [15:0]        object_id,
    input  logic signed [15:0] period,
    input  logic               has_handler,
    output logic               busy,
    output logic               strobe,
    output logic [1:0]         status,
    output logic [14:0]        period_value,
    output logic               fired,
    output logic [15:0]        fired_id,
    output logic               last
);
    import ptt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_FIND,
        S_APPLY
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [1:0]         kind_reg;
    logic [15:0]        id_reg;
    logic signed [15:0] period_reg;
    logic               handler_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [14:0]        found_per_reg;
    logic               found_hnd_reg;
    logic               closing_reg;

    logic               strobe_reg;
    logic [1:0]         status_reg;
    logic [14:0]        pv_reg;
    logic               fired_reg;
    logic [15:0]        fired_id_reg;
    logic               last_reg;

    entry_t             head;
    entry_t             tail_data;
    entry_t             load_data;
    chain_cmd_t         cmd;
    logic [IDX_W-1:0]   chain_pos;
    tick_res_t          tick_res;
    logic               in_range;
    logic               walk_end;

    logic               ap_load;
    logic               ap_compact;
    logic               ap_inc;
    logic               ap_dec;
    logic [1:0]         ap_status;
    logic [14:0]        ap_pv;

    assign in_range = CNT_W'(idx_reg) < count_reg;
    assign walk_end = idx_reg == IDX_W'(TABLE_DEPTH - 1);
    assign tick_res = tick_entry(head);

    // decision taken once the search walk is over
    always_comb
    begin
        logic neg;
        logic zero;
        neg        = period_reg[15];
        zero       = period_reg == 16'sd0;
        ap_load    = 1'b0;
        ap_compact = 1'b0;
        ap_inc     = 1'b0;
        ap_dec     = 1'b0;
        ap_status  = STATUS_NONE;
        ap_pv      = '0;
        load_data.obj = id_reg;
        load_data.per = neg ? 15'd1 : period_reg[14:0];
        load_data.cnt = neg ? 16'd1 : period_reg;
        load_data.hnd = found_reg ? found_hnd_reg : handler_reg;
        if (kind_reg == KIND_QUERY)
        begin
            if (found_reg)
            begin
                ap_status = STATUS_DONE;
                ap_pv     = found_per_reg;
            end
        end
        else if (zero)
        begin
            if (found_reg)
            begin
                ap_compact = 1'b1;
                ap_dec     = 1'b1;
                ap_status  = STATUS_DONE;
            end
        end
        else if (found_reg)
        begin
            if (!neg)
            begin
                ap_load   = 1'b1;
                ap_status = STATUS_DONE;
            end
        end
        else if (count_reg == CNT_W'(TABLE_DEPTH))
        begin
            ap_status = STATUS_FULL;
        end
        else
        begin
            ap_load   = 1'b1;
            ap_inc    = 1'b1;
            ap_status = STATUS_DONE;
        end
    end

    always_comb
    begin
        cmd.rotate  = ((state_reg == S_TICK) && !closing_reg) || (state_reg == S_FIND);
        cmd.compact = (state_reg == S_APPLY) && ap_compact;
        cmd.load    = (state_reg == S_APPLY) && ap_load;
        chain_pos   = found_reg ? pos_reg : count_reg[IDX_W-1:0];
        if ((state_reg == S_TICK) && in_range)
        begin
            tail_data = tick_res.e;
        end
        else
        begin
            tail_data = head;
        end
    end

    ptt_chain #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_chain (
        .clk       (clk),
        .cmd       (cmd),
        .pos       (chain_pos),
        .tail_data (tail_data),
        .load_data (load_data),
        .head      (head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            kind_reg      <= '0;
            id_reg        <= '0;
            period_reg    <= '0;
            handler_reg   <= 1'b0;
            found_reg     <= 1'b0;
            pos_reg       <= '0;
            found_per_reg <= '0;
            found_hnd_reg <= 1'b0;
            closing_reg   <= 1'b0;
            strobe_reg    <= 1'b0;
            status_reg    <= '0;
            pv_reg        <= '0;
            fired_reg     <= 1'b0;
            fired_id_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg   <= 1'b0;
            status_reg   <= STATUS_NONE;
            pv_reg       <= '0;
            fired_reg    <= 1'b0;
            fired_id_reg <= '0;
            last_reg     <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg    <= kind;
                        id_reg      <= object_id;
                        period_reg  <= period;
                        handler_reg <= has_handler;
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                        closing_reg <= 1'b0;
                        if (kind == KIND_TICK)
                        begin
                            state_reg <= S_TICK;
                        end
                        else if ((kind == KIND_SET) || (kind == KIND_QUERY))
                        begin
                            state_reg <= S_FIND;
                        end
                        else
                        begin
                            strobe_reg <= 1'b1;
                            last_reg   <= 1'b1;
                        end
                    end
                end
                S_TICK:
                begin
                    if (closing_reg)
                    begin
                        strobe_reg <= 1'b1;
                        status_reg <= STATUS_DONE;
                        last_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        if (in_range && tick_res.fire)
                        begin
                            strobe_reg   <= 1'b1;
                            status_reg   <= STATUS_DONE;
                            fired_reg    <= 1'b1;
                            fired_id_reg <= head.obj;
                        end
                        idx_reg <= idx_reg + 1'b1;
                        if (walk_end)
                        begin
                            idx_reg     <= '0;
                            closing_reg <= 1'b1;
                        end
                    end
                end
                S_FIND:
                begin
                    if (in_range && (head.obj == id_reg))
                    begin
                        found_reg     <= 1'b1;
                        pos_reg       <= idx_reg;
                        found_per_reg <= head.per;
                        found_hnd_reg <= head.hnd;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (walk_end)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    strobe_reg <= 1'b1;
                    status_reg <= ap_status;
                    pv_reg     <= ap_pv;
                    last_reg   <= 1'b1;
                    if (ap_inc)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    else if (ap_dec)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign strobe       = strobe_reg;
    assign status       = status_reg;
    assign period_value = pv_reg;
    assign fired        = fired_reg;
    assign fired_id     = fired_id_reg;
    assign last         = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && fired) |-> (!last && busy))
        else $error("fire beat outside a tick walk or marked last");

    a_close_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && last))
        else $error("command finished without a closing beat");

    a_full_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status == STATUS_FULL)) |-> (count_reg == CNT_W'(TABLE_DEPTH)))
        else $error("table full reported with free entries");

endmodule
